// File: rtl/core/apm_pkg.sv
// Shared types, constants and helpers for the all-pairs shortest path core.
package apm_pkg;

  localparam int MAX_NODES   = 64;
  localparam int DIST_BITS   = 24;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int NC_W        = 7;
  localparam int DRAIN_CYC   = MAX_NODES + 3;
  localparam int DRAIN_W     = $clog2(DRAIN_CYC + 1);

  localparam logic [DIST_BITS-1:0] DIST_ALL1 = {DIST_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_RUN_COL,
    ST_RUN_LATCH,
    ST_RUN_FEED,
    ST_RUN_DRAIN,
    ST_FINISH
  } state_e;

  // One element of row k travelling down the chain.
  typedef struct packed {
    logic                 vld;
    logic [NODE_W-1:0]    col;
    logic [DIST_BITS-1:0] dkj;
  } tok_t;

  typedef struct packed {
    logic                 ovr_en;
    logic [NODE_W-1:0]    ovr_addr;
    logic                 wr_en;
    logic [NODE_W-1:0]    wr_addr;
    logic [DIST_BITS-1:0] wr_data;
    logic                 latch_dik;
    logic                 upd_en;
  } cell_ctl_t;

  function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
                                                   input logic [DIST_BITS-1:0] b);
    logic [DIST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == DIST_ALL1 || b == DIST_ALL1 || s >= {1'b0, DIST_ALL1}) begin
      return DIST_ALL1;
    end
    return s[DIST_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/apm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/apm_cell.sv
// One chain cell: holds one matrix row and relaxes it against the passing row k.
module apm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apm_pkg::cell_ctl_t            ctl_i,
  input  apm_pkg::tok_t                 tok_i,
  output apm_pkg::tok_t                 tok_o,
  output logic [apm_pkg::DIST_BITS-1:0] rdata_o
);
  import apm_pkg::*;

  tok_t                 hold_q;
  logic [DIST_BITS-1:0] dik_q;
  logic [DIST_BITS-1:0] rdata;
  logic [DIST_BITS-1:0] via;
  logic [NODE_W-1:0]    raddr;
  logic                 we;
  logic [NODE_W-1:0]    waddr;
  logic [DIST_BITS-1:0] wdata;
  logic                 upd;

  assign raddr = ctl_i.ovr_en ? ctl_i.ovr_addr : tok_i.col;
  assign via   = sat_add(dik_q, hold_q.dkj);
  // rdata here is D[i][j] for the token now held
  assign upd   = hold_q.vld && ctl_i.upd_en && (via < rdata);

  always_comb begin
    we    = ctl_i.wr_en;
    waddr = ctl_i.wr_addr;
    wdata = ctl_i.wr_data;
    if (upd) begin
      we    = 1'b1;
      waddr = hold_q.col;
      wdata = via;
    end
  end

  apm_ram #(
    .WIDTH(DIST_BITS),
    .DEPTH(MAX_NODES)
  ) u_row (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else begin
      hold_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_dik) begin
      dik_q <= rdata;
    end
  end

  assign tok_o   = hold_q;
  assign rdata_o = rdata;

endmodule

// File: rtl/core/all_pairs_shortest_path_matrix_core.sv
// Top level: command sequencer and chain of row cells for all-pairs shortest paths.
//
// Input items arrive on s_axis: tuser carries the operation (clear, add edge,
// run, read), tdata the two node indices and the Q8.8 weight. Each item gives
// exactly one result item on m_axis: tdata is the Q16.8 distance of a read,
// tuser flags unreachable and index error. node_count is set via cfg_we_i.
// Each matrix row lives in its own cell; during a run row k is streamed down
// the chain one element per cycle and every cell below node_count other than
// cell k relaxes its row in place. A clear writes one row slot per cycle, all
// cells in parallel; for each k a run does the column fetch and latch, the
// row k feed and the chain drain.
// One item is worked on at a time; s_axis_tready is high only while idle.
// A finished result waits in a holding register; the next item is accepted
// while the previous result still sits on m_axis, and a stalled receiver
// only delays the load of the next result.
// Reset clears control state and sets node_count to 64; the matrix stays
// undefined until a clear item.
module all_pairs_shortest_path_matrix_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,   // node_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row_node[5:0], col_node[11:6], weight[27:12], zero pad
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // distance
  output logic [1:0]  m_axis_tuser   // unreachable[0], error[1]
);
  import apm_pkg::*;

  state_e               state_q, state_d;
  logic [NC_W-1:0]      nc_q;
  logic [NC_W-1:0]      n_eff;
  op_e                  op;
  logic [NODE_W-1:0]    u_q, v_q;
  logic [DIST_BITS-1:0] w_q;
  logic [NODE_W-1:0]    kk_q, kk_d, jj_q, jj_d, cc_q, cc_d;
  logic [DRAIN_W-1:0]   dr_q, dr_d;
  logic [DIST_BITS-1:0] rdist_q, rdist_d;
  logic                 runr_q, runr_d, rerr_q, rerr_d;
  logic                 ovalid_q;
  logic [DIST_BITS-1:0] odist_q;
  logic                 ounr_q, oerr_q;
  logic                 out_free, load_out, accept, in_err;
  logic                 feed_vld_q;
  logic [NODE_W-1:0]    feed_col_q;
  logic                 kk_last, jj_last;

  tok_t                 tok  [MAX_NODES+1];
  logic [DIST_BITS-1:0] rd   [MAX_NODES];
  cell_ctl_t            ctl  [MAX_NODES];

  assign n_eff    = (nc_q > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : nc_q;
  assign op       = op_e'(s_axis_tuser);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_err   = ({1'b0, s_axis_tdata[5:0]} >= n_eff) ||
                    ({1'b0, s_axis_tdata[11:6]} >= n_eff);
  assign out_free = !ovalid_q || m_axis_tready;
  assign load_out = (state_q == ST_FINISH) && out_free;
  assign kk_last  = ({1'b0, kk_q} == n_eff - NC_W'(1));
  assign jj_last  = ({1'b0, jj_q} == n_eff - NC_W'(1));
  assign s_axis_tready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_CLEAR: state_d = ST_CLEAR;
            OP_RUN:   state_d = (n_eff == '0) ? ST_FINISH : ST_RUN_COL;
            OP_ADD:   state_d = in_err ? ST_FINISH : ST_ADD;
            OP_READ:  state_d = in_err ? ST_FINISH : ST_RD_ISSUE;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR:     if (cc_q == NODE_W'(MAX_NODES - 1)) state_d = ST_FINISH;
      ST_ADD:       state_d = ST_FINISH;
      ST_RD_ISSUE:  state_d = ST_RD_DATA;
      ST_RD_DATA:   state_d = ST_FINISH;
      ST_RUN_COL:   state_d = ST_RUN_LATCH;
      ST_RUN_LATCH: state_d = ST_RUN_FEED;
      ST_RUN_FEED:  if (jj_last) state_d = ST_RUN_DRAIN;
      ST_RUN_DRAIN: begin
        if (dr_q == DRAIN_W'(DRAIN_CYC)) state_d = kk_last ? ST_FINISH : ST_RUN_COL;
      end
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // counters and result
  always_comb begin
    kk_d    = kk_q;
    jj_d    = jj_q;
    cc_d    = cc_q;
    dr_d    = dr_q;
    rdist_d = rdist_q;
    runr_d  = runr_q;
    rerr_d  = rerr_q;
    unique case (state_q)
      ST_IDLE: begin
        kk_d    = '0;
        cc_d    = '0;
        rdist_d = '0;
        runr_d  = 1'b0;
        rerr_d  = accept && (op == OP_ADD || op == OP_READ) && in_err;
      end
      ST_CLEAR:     cc_d = cc_q + NODE_W'(1);
      ST_RD_DATA: begin
        rdist_d = rd[u_q];
        runr_d  = (rd[u_q] == DIST_ALL1);
      end
      ST_RUN_LATCH: jj_d = '0;
      ST_RUN_FEED: begin
        jj_d = jj_q + NODE_W'(1);
        dr_d = '0;
      end
      ST_RUN_DRAIN: begin
        dr_d = dr_q + DRAIN_W'(1);
        if (dr_q == DRAIN_W'(DRAIN_CYC)) kk_d = kk_q + NODE_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      nc_q       <= NC_W'(MAX_NODES);
      ovalid_q   <= 1'b0;
      feed_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      feed_vld_q <= (state_q == ST_RUN_FEED);
      if (cfg_we_i) nc_q <= cfg_wdata_i;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kk_q       <= kk_d;
    jj_q       <= jj_d;
    cc_q       <= cc_d;
    dr_q       <= dr_d;
    rdist_q    <= rdist_d;
    runr_q     <= runr_d;
    rerr_q     <= rerr_d;
    feed_col_q <= jj_q;
    if (accept) begin
      u_q <= s_axis_tdata[5:0];
      v_q <= s_axis_tdata[11:6];
      w_q <= DIST_BITS'(s_axis_tdata[27:12]);
    end
    if (load_out) begin
      odist_q <= rdist_q;
      ounr_q  <= runr_q;
      oerr_q  <= rerr_q;
    end
  end

  // chain head: row k element fetched from cell k the cycle before
  assign tok[0].vld = feed_vld_q;
  assign tok[0].col = feed_col_q;
  assign tok[0].dkj = rd[kk_q];

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    localparam logic [NODE_W-1:0] IDX = NODE_W'(i);
    always_comb begin
      ctl[i].ovr_en    = (state_q == ST_RUN_COL) ||
                         (state_q == ST_RUN_FEED && kk_q == IDX) ||
                         (state_q == ST_RD_ISSUE && u_q == IDX);
      ctl[i].ovr_addr  = (state_q == ST_RUN_COL)  ? kk_q :
                         (state_q == ST_RUN_FEED) ? jj_q : v_q;
      ctl[i].wr_en     = (state_q == ST_CLEAR) ||
                         (state_q == ST_ADD && (u_q == IDX || v_q == IDX));
      ctl[i].wr_addr   = (state_q == ST_CLEAR) ? cc_q : ((u_q == IDX) ? v_q : u_q);
      ctl[i].wr_data   = (state_q == ST_CLEAR) ? ((cc_q == IDX) ? '0 : DIST_ALL1) : w_q;
      ctl[i].latch_dik = (state_q == ST_RUN_LATCH);
      // row k does not change during pass k
      ctl[i].upd_en    = (NC_W'(i) < n_eff) && (kk_q != IDX);
    end

    apm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[i]),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1]),
      .rdata_o (rd[i])
    );
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odist_q;
  assign m_axis_tuser  = {oerr_q, ounr_q};

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item did not start work");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("finished result not presented");

  a_err_no_unr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("error and unreachable both set");

  a_err_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
    else $error("distance nonzero on error");

endmodule

// File: test/all_pairs_shortest_path_matrix_core_tb.sv
// Self-checking testbench for the all-pairs shortest path matrix core.
`timescale 1ns / 100ps

module all_pairs_shortest_path_matrix_core_tb;
  import apm_pkg::*;

  localparam int STALL_LIMIT = 80000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [DIST_BITS-1:0] dist_val;
    logic                 unr;
    logic                 err;
  } path_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  all_pairs_shortest_path_matrix_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the block state
  logic [DIST_BITS-1:0] dist_mat [MAX_NODES][MAX_NODES];
  logic [NC_W-1:0]      node_cnt;
  path_res_t            pending_dist_q[$];
  int                   fail_cnt;
  bit                   idle_en;
  bit                   hold_req;
  int                   quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DIST_BITS-1:0] path_add(logic [DIST_BITS-1:0] a,
                                                    logic [DIST_BITS-1:0] b);
    logic [DIST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == DIST_ALL1 || b == DIST_ALL1 || s >= {1'b0, DIST_ALL1}) return DIST_ALL1;
    return s[DIST_BITS-1:0];
  endfunction

  task automatic predict_path(input op_e op, input logic [5:0] u, input logic [5:0] v,
                              input logic [15:0] w, output path_res_t r);
    int n;
    logic [DIST_BITS-1:0] via;
    n = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
    r = '0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < MAX_NODES; i++)
          for (int j = 0; j < MAX_NODES; j++)
            dist_mat[i][j] = (i == j) ? '0 : DIST_ALL1;
      end
      OP_RUN: begin
        for (int k = 0; k < n; k++)
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
              via = path_add(dist_mat[i][k], dist_mat[k][j]);
              if (via < dist_mat[i][j]) dist_mat[i][j] = via;
            end
      end
      default: begin
        if (u >= n || v >= n) begin
          r.err = 1'b1;
        end else if (op == OP_ADD) begin
          dist_mat[u][v] = {8'd0, w};
          dist_mat[v][u] = {8'd0, w};
        end else begin
          r.dist_val = dist_mat[u][v];
          r.unr      = (dist_mat[u][v] == DIST_ALL1);
        end
      end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input op_e op, input logic [5:0] u, input logic [5:0] v,
                           input logic [15:0] w);
    path_res_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'd0, w, v, u};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_path(op, u, v, w, r);
    pending_dist_q = {pending_dist_q, r};
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_dist_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic set_node_count(input logic [6:0] nc);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = nc;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    node_cnt = nc;
  endtask

  task automatic test_full_size();
    send_item(OP_CLEAR, 6'd0, 6'd0, 16'd0);
    send_item(OP_READ, 6'd5, 6'd6, 16'd0);
    send_item(OP_READ, 6'd7, 6'd7, 16'd0);
    send_item(OP_ADD, 6'd0, 6'd63, 16'hFFFF);
    send_item(OP_ADD, 6'd63, 6'd63, 16'h1234);
    send_item(OP_ADD, 6'd1, 6'd63, 16'h0000);
    send_item(OP_READ, 6'd63, 6'd0, 16'h0);
    send_item(OP_READ, 6'd63, 6'd63, 16'h0);
    send_item(OP_RUN, 6'd0, 6'd0, 16'd0);
    send_item(OP_READ, 6'd0, 6'd1, 16'd0);
    send_item(OP_READ, 6'd63, 6'd63, 16'd0);
  endtask

  task automatic test_small_graph();
    set_node_count(7'd4);
    send_item(OP_ADD, 6'd4, 6'd0, 16'd1);
    send_item(OP_READ, 6'd0, 6'd4, 16'd0);
    send_item(OP_ADD, 6'd0, 6'd1, 16'h0100);
    send_item(OP_ADD, 6'd1, 6'd2, 16'h0200);
    send_item(OP_ADD, 6'd0, 6'd1, 16'h0080);
    send_item(OP_RUN, 6'd0, 6'd0, 16'd0);
    send_item(OP_READ, 6'd0, 6'd2, 16'd0);
    send_item(OP_READ, 6'd2, 6'd0, 16'd0);
    send_item(OP_READ, 6'd3, 6'd3, 16'd0);
    send_item(OP_READ, 6'd0, 6'd3, 16'd0);
  endtask

  task automatic test_count_extremes();
    set_node_count(7'd0);
    send_item(OP_ADD, 6'd0, 6'd0, 16'd5);
    send_item(OP_READ, 6'd0, 6'd0, 16'd0);
    send_item(OP_RUN, 6'd0, 6'd0, 16'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0, 16'd0);
    set_node_count(7'd127);
    send_item(OP_READ, 6'd63, 6'd0, 16'd0);
    send_item(OP_ADD, 6'd63, 6'd62, 16'hABCD);
    send_item(OP_READ, 6'd62, 6'd63, 16'd0);
    set_node_count(7'd1);
    send_item(OP_ADD, 6'd0, 6'd1, 16'd9);
    send_item(OP_READ, 6'd0, 6'd0, 16'd0);
  endtask

  task automatic test_random(input int phases, input int per_phase);
    int n, sel, pick;
    logic [5:0] u, v;
    logic [15:0] w;
    op_e op;
    for (int p = 0; p < phases; p++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: set_node_count(7'd0);
        1: set_node_count(7'd1);
        2: set_node_count(7'($urandom_range(64, 127)));
        3: set_node_count(7'($urandom_range(9, 20)));
        default: set_node_count(7'($urandom_range(2, 8)));
      endcase
      if (p == 1 && idle_en) hold_req = 1'b1;
      n = (node_cnt > MAX_NODES) ? MAX_NODES : node_cnt;
      if ($urandom_range(0, 2) == 0) send_item(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
      for (int i = 0; i < per_phase; i++) begin
        sel = $urandom_range(0, 99);
        if (n > 0 && sel < 85) begin
          u = 6'($urandom_range(0, n - 1));
          v = 6'($urandom_range(0, n - 1));
        end else begin
          u = 6'($urandom);
          v = 6'($urandom);
        end
        w = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45) op = OP_ADD;
        else if (sel < 90) op = OP_READ;
        else if (sel < 96 && n <= 20) op = OP_RUN;
        else if (sel < 98) op = OP_CLEAR;
        else op = OP_READ;
        send_item(op, u, v, w);
      end
    end
  endtask

  // receiver side handshake
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    path_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_dist_q.size() == 0) begin
        $display("%0t: unexpected result dist=%h user=%b", $time, m_axis_tdata, m_axis_tuser);
        fail_cnt++;
      end else begin
        want = pending_dist_q.pop_front();
        if (m_axis_tdata !== want.dist_val) begin
          $display("%0t: distance expected %h actual %h", $time, want.dist_val, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tuser[0] !== want.unr) begin
          $display("%0t: unreachable expected %b actual %b", $time, want.unr, m_axis_tuser[0]);
          fail_cnt++;
        end
        if (m_axis_tuser[1] !== want.err) begin
          $display("%0t: error expected %b actual %b", $time, want.err, m_axis_tuser[1]);
          fail_cnt++;
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    fail_cnt      = 0;
    quiet_cycles  = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    node_cnt      = 7'd64;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CLEAR;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_full_size();
    test_small_graph();
    test_count_extremes();
    test_random(6, 55);
    idle_en = 1'b0;
    test_random(2, 55);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
